// ===== sv/nested_scope_tick_profiler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nested scope tick profiler
// Shared property forms, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NESTED_SCOPE_TICK_PROFILER_ASSERT_SVH
`define NESTED_SCOPE_TICK_PROFILER_ASSERT_SVH

// Check that a condition holds at every edge
`define NSTP_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define NSTP_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== sv/nstp_pkg.sv =====
// ----------------------------------------------------------------------------
// nstp_pkg
// Sizes, codes, frame layout and controller types for the scope profiler.
// ----------------------------------------------------------------------------
package nstp_pkg;

	// Table and stack sizes
	localparam int NUM_SCOPES = 1024;
	localparam int MAX_DEPTH  = 32;

	// Field widths of the word format
	localparam int FUNC_W  = 2;
	localparam int ID_W    = 10;
	localparam int TICK_W  = 64;
	localparam int STAT_W  = 2;
	localparam int DEPTH_W = 6;
	localparam int COUNT_W = 11;

	// Derived storage widths
	localparam int SCOPE_AW = $clog2(NUM_SCOPES);
	localparam int FRAME_AW = $clog2(MAX_DEPTH);
	localparam int SP_W     = $clog2(MAX_DEPTH + 1);
	localparam int ACT_W    = $clog2(NUM_SCOPES + 1);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EXIT  = 2'd1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd3;

	// One stack frame; child time is kept apart
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] start;
		logic [TICK_W-1:0] saved;
	} frame_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_EXIT2,
		ST_EXIT3
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic exec;
		logic exit_rd;
		logic exit_calc;
		logic exit_wr;
	} nstp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic op_exit;
		logic stack_empty;
	} nstp_stat_t;

endpackage

// ===== sv/nested_scope_tick_profiler.sv =====
// ----------------------------------------------------------------------------
// nested_scope_tick_profiler
// Scope stack profiler with per-id inclusive and exclusive tick totals.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func, scope_id and timestamp with start high; the word is taken at
//   the edge where start is high and busy is low. Each word gives one result
//   word, shown for one cycle with done high; the receiver cannot stall, so
//   it must take the result in that cycle.
//   Enter and read words pass through capture and execute, with done high in
//   the cycle after execute. An exit with an open scope steps through reading
//   the top frame, reading the scope's totals at the frame's id, then two add
//   steps on the 64-bit tick values. An exit on an empty stack passes through
//   capture and execute only. The per-id tables are simple dual-port memories,
//   one read and one write per cycle, which sets the step count.
//   After reset the mark table is swept to zero, one entry a cycle, over all
//   1024 entries with busy high; the tick tables are trusted only where the
//   mark is set, and a first entry writes them to zero.
//   The result registers sit apart from the input side, so a new word is
//   taken while done still shows the previous result.
// ----------------------------------------------------------------------------
module nested_scope_tick_profiler import nstp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ID_W-1:0]     scope_id,
	input  logic [TICK_W-1:0]   timestamp,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [ID_W-1:0]     result_id,
	output logic [TICK_W-1:0]   incl_ticks,
	output logic [TICK_W-1:0]   excl_ticks,
	output logic                registered,
	output logic [DEPTH_W-1:0]  nesting_depth,
	output logic [COUNT_W-1:0]  active_count
);

	nstp_cmd_t  cmd;
	nstp_stat_t stat;

	// Sequence each word
	nstp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Stack, tables and result word
	nstp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.scope_id      (scope_id),
		.timestamp     (timestamp),
		.done          (done),
		.status        (status),
		.result_id     (result_id),
		.incl_ticks    (incl_ticks),
		.excl_ticks    (excl_ticks),
		.registered    (registered),
		.nesting_depth (nesting_depth),
		.active_count  (active_count)
	);

endmodule

// ===== sv/nstp_ctrl.sv =====
// ----------------------------------------------------------------------------
// nstp_ctrl
// Sequencer: clears the mark table after reset, then steps each word
// through capture and execute, and an exit with an open scope through the three-step exit path.
// ----------------------------------------------------------------------------
`include "nested_scope_tick_profiler_assert.svh"

module nstp_ctrl import nstp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  nstp_stat_t stat,
	output nstp_cmd_t  cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.op_exit && !stat.stack_empty) begin
					state_d = ST_EXIT2;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EXIT2: state_d = ST_EXIT3;
			ST_EXIT3: state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Drive commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_EXEC: begin
				if (stat.op_exit && !stat.stack_empty) begin
					cmd.exit_rd = 1'b1;
				end else begin
					cmd.exec = 1'b1;
				end
			end
			ST_EXIT2: cmd.exit_calc = 1'b1;
			ST_EXIT3: cmd.exit_wr   = 1'b1;
			default:  cmd = '0;
		endcase
	end

	`NSTP_ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec || cmd.exit_rd, "capture not followed by execute")
	`NSTP_ASSERT_NEXT(a_exit_rd_then_calc, cmd.exit_rd, cmd.exit_calc, "exit read not followed by calc")
	`NSTP_ASSERT_NEXT(a_exit_calc_then_wr, cmd.exit_calc, cmd.exit_wr && busy, "exit calc not followed by write")

endmodule

// ===== sv/nstp_datapath.sv =====
// ----------------------------------------------------------------------------
// nstp_datapath
// Scope stack, per-id tick tables, mark table and the result registers.
// ----------------------------------------------------------------------------
`include "nested_scope_tick_profiler_assert.svh"

module nstp_datapath import nstp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  nstp_cmd_t           cmd,
	output nstp_stat_t          stat,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ID_W-1:0]     scope_id,
	input  logic [TICK_W-1:0]   timestamp,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [ID_W-1:0]     result_id,
	output logic [TICK_W-1:0]   incl_ticks,
	output logic [TICK_W-1:0]   excl_ticks,
	output logic                registered,
	output logic [DEPTH_W-1:0]  nesting_depth,
	output logic [COUNT_W-1:0]  active_count
);

	// Captured word
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [TICK_W-1:0] ts_q;

	// Memories
	frame_t            frame_mem [MAX_DEPTH];
	logic [TICK_W-1:0] child_mem [MAX_DEPTH];
	logic [TICK_W-1:0] incl_mem  [NUM_SCOPES];
	logic [TICK_W-1:0] excl_mem  [NUM_SCOPES];
	logic              mark_mem  [NUM_SCOPES];

	// Registered read data
	frame_t            frame_rd_q;
	logic [TICK_W-1:0] child_rd_q;
	logic [TICK_W-1:0] incl_rd_q;
	logic [TICK_W-1:0] excl_rd_q;
	logic              mark_rd_q;

	// Control state
	logic [SP_W-1:0]     sp_q;
	logic [ACT_W-1:0]    hpo_q;
	logic [SCOPE_AW-1:0] clr_cnt_q;
	logic                done_q;

	// Exit arithmetic
	logic [TICK_W-1:0] top_child_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] incl_new_q;
	logic [TICK_W-1:0] delta_q;

	// Result registers
	logic [STAT_W-1:0]  res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [TICK_W-1:0]  res_incl_q;
	logic [TICK_W-1:0]  res_excl_q;
	logic               res_reg_q;
	logic [DEPTH_W-1:0] res_depth_q;
	logic [COUNT_W-1:0] res_count_q;

	// Decode
	logic                is_exit;
	logic                is_enter;
	logic                bad_id;
	logic                full;
	logic                empty;
	logic                enter_ok;
	logic                new_reg;
	logic [TICK_W-1:0]   cur_incl;
	logic [TICK_W-1:0]   cur_excl;
	logic [FRAME_AW-1:0] push_idx;
	logic [FRAME_AW-1:0] top_idx;
	logic [FRAME_AW-1:0] par_idx;
	logic [SCOPE_AW-1:0] tbl_rd_addr;
	logic [SCOPE_AW-1:0] tbl_wr_addr;
	logic                tbl_wr_en;
	logic [TICK_W-1:0]   incl_wr_data;
	logic [TICK_W-1:0]   excl_wr_data;
	logic [TICK_W-1:0]   excl_new;
	logic [SP_W-1:0]     sp_d;
	logic [ACT_W-1:0]    hpo_d;

	always_comb begin
		is_exit  = (func_q == FUNC_EXIT);
		is_enter = (func_q == FUNC_ENTER);
		bad_id   = (32'(id_q) >= NUM_SCOPES);
		full     = (sp_q >= SP_W'(MAX_DEPTH));
		empty    = (sp_q == '0);
		enter_ok = cmd.exec && is_enter && !bad_id && !full;
		new_reg  = enter_ok && !mark_rd_q;
		cur_incl = mark_rd_q ? incl_rd_q : '0;
		cur_excl = mark_rd_q ? excl_rd_q : '0;
		push_idx = FRAME_AW'(sp_q);
		top_idx  = FRAME_AW'(sp_q - SP_W'(1));
		par_idx  = FRAME_AW'(sp_q - SP_W'(2));
		excl_new = excl_rd_q + delta_q;
	end

	assign stat.clear_done  = (clr_cnt_q == SCOPE_AW'(NUM_SCOPES - 1));
	assign stat.op_exit     = is_exit;
	assign stat.stack_empty = empty;

	// Next depth and highest-id-plus-one
	always_comb begin
		sp_d  = sp_q;
		hpo_d = hpo_q;
		if (enter_ok) begin
			sp_d = sp_q + SP_W'(1);
		end else if (cmd.exit_wr) begin
			sp_d = sp_q - SP_W'(1);
		end
		if (new_reg && (ACT_W'(id_q) >= hpo_q)) begin
			hpo_d = ACT_W'(id_q) + ACT_W'(1);
		end
	end

	// Capture the incoming word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			id_q   <= scope_id;
			ts_q   <= timestamp;
		end
	end

	// Read the top and parent frames at capture; push on enter
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_rd_q <= frame_mem[top_idx];
			child_rd_q <= child_mem[par_idx];
		end
		if (enter_ok) begin
			frame_mem[push_idx] <= '{id: id_q, start: ts_q, saved: cur_incl};
		end
		if (enter_ok && !empty) begin
			child_mem[top_idx] <= top_child_q;
		end
	end

	// Table ports: read by word id at capture, by frame id on exit
	always_comb begin
		tbl_rd_addr  = cmd.capture ? SCOPE_AW'(scope_id) : SCOPE_AW'(frame_rd_q.id);
		tbl_wr_addr  = cmd.exit_wr ? SCOPE_AW'(frame_rd_q.id) : SCOPE_AW'(id_q);
		tbl_wr_en    = cmd.exit_wr || new_reg;
		incl_wr_data = cmd.exit_wr ? incl_new_q : '0;
		excl_wr_data = cmd.exit_wr ? excl_new : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture || cmd.exit_rd) begin
			incl_rd_q <= incl_mem[tbl_rd_addr];
			excl_rd_q <= excl_mem[tbl_rd_addr];
			mark_rd_q <= mark_mem[tbl_rd_addr];
		end
		if (tbl_wr_en) begin
			incl_mem[tbl_wr_addr] <= incl_wr_data;
			excl_mem[tbl_wr_addr] <= excl_wr_data;
		end
		if (cmd.clr_wr) begin
			mark_mem[clr_cnt_q] <= 1'b0;
		end else if (new_reg) begin
			mark_mem[tbl_wr_addr] <= 1'b1;
		end
	end

	// Exit arithmetic: elapsed, then totals and parent child time
	always_ff @(posedge clk) begin
		if (cmd.exit_rd) begin
			elapsed_q <= ts_q - frame_rd_q.start;
		end
		if (cmd.exit_calc) begin
			incl_new_q <= frame_rd_q.saved + elapsed_q;
			delta_q    <= elapsed_q - top_child_q;
		end
	end

	// Child time of the innermost open frame
	always_ff @(posedge clk) begin
		if (enter_ok) begin
			top_child_q <= '0;
		end else if (cmd.exit_calc) begin
			top_child_q <= child_rd_q + elapsed_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			hpo_q     <= '0;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			sp_q   <= sp_d;
			hpo_q  <= hpo_d;
			done_q <= cmd.exec || cmd.exit_wr;
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + SCOPE_AW'(1);
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.exit_wr) begin
			res_status_q <= STAT_OK;
			res_id_q     <= frame_rd_q.id;
			res_incl_q   <= incl_new_q;
			res_excl_q   <= excl_new;
			res_reg_q    <= mark_rd_q;
		end else if (cmd.exec) begin
			if (is_exit) begin
				res_status_q <= STAT_EMPTY;
				res_id_q     <= '0;
				res_incl_q   <= '0;
				res_excl_q   <= '0;
				res_reg_q    <= 1'b0;
			end else if (bad_id) begin
				res_status_q <= STAT_BAD_ID;
				res_id_q     <= id_q;
				res_incl_q   <= '0;
				res_excl_q   <= '0;
				res_reg_q    <= 1'b0;
			end else begin
				res_status_q <= (is_enter && full) ? STAT_FULL : STAT_OK;
				res_id_q     <= id_q;
				res_incl_q   <= cur_incl;
				res_excl_q   <= cur_excl;
				res_reg_q    <= mark_rd_q || enter_ok;
			end
		end
		if (cmd.exec || cmd.exit_wr) begin
			res_depth_q <= DEPTH_W'(sp_d);
			res_count_q <= COUNT_W'(hpo_d);
		end
	end

	assign done          = done_q;
	assign status        = res_status_q;
	assign result_id     = res_id_q;
	assign incl_ticks    = res_incl_q;
	assign excl_ticks    = res_excl_q;
	assign registered    = res_reg_q;
	assign nesting_depth = res_depth_q;
	assign active_count  = res_count_q;

	`NSTP_ASSERT_ALWAYS(a_sp_in_range, sp_q <= SP_W'(MAX_DEPTH), "stack pointer beyond depth")
	`NSTP_ASSERT_ALWAYS(a_hpo_in_range, hpo_q <= ACT_W'(NUM_SCOPES), "active count beyond table")
	`NSTP_ASSERT_NEXT(a_exit_pops, cmd.exit_wr, sp_q == $past(sp_q) - SP_W'(1), "exit did not pop")

endmodule
